### rtl/core/lpr_pkg.sv
package lpr_pkg;

  localparam int PAGE_W     = 16;
  localparam int INDEX_W    = 4;
  localparam int COUNT_W    = 32;
  localparam int FC_W       = 5;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [FC_W-1:0] FRAME_COUNT_RST = 5'd16;

  // register select is paddr[2]; one register at word 0
  localparam logic REG_FRAME_COUNT = 1'b0;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              start_seq;
    logic              last_ref;
  } lpr_item_t;

  typedef struct packed {
    logic               fault;
    logic [INDEX_W-1:0] frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_total;
    logic               seq_end;
  } lpr_result_t;

endpackage

### rtl/core/lru_page_replacement_top.sv
// Inputs are registered in item_r and results in res_r; out_valid rises with the registered result.
// Throughput: one transaction per cycle; lookup, fill and LRU update of all frames
// complete combinationally between the input and result registers.
// busy stays low, and results are strobed for one cycle with no backpressure.
// Reset (rst_n, synchronous, active low) invalidates all frames, clears the fault
// count and sets frame_count to 16.
module lru_page_replacement_top import lpr_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [PAGE_W-1:0]     in_page,
  input  logic                  in_start_sequence,
  input  logic                  in_last_reference,
  output logic                  out_valid,
  output logic                  out_fault,
  output logic [INDEX_W-1:0]    out_frame_index,
  output logic                  out_evicted_valid,
  output logic [PAGE_W-1:0]     out_evicted_page,
  output logic [COUNT_W-1:0]    out_fault_total,
  output logic                  out_sequence_end,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int NW = $clog2(FRAMES + 1);

  logic [FC_W-1:0]   frame_count_r;
  logic [NW-1:0]     n_active;
  logic [FRAMES-1:0] act;
  logic              item_v_r, out_valid_r;
  lpr_item_t         item_r;
  lpr_result_t       res, res_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_COUNT) ? APB_DATA_W'(frame_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_FRAME_COUNT) begin
      frame_count_r <= pwdata[FC_W-1:0];
    end
  end

  always_comb begin
    if (frame_count_r == '0) begin
      n_active = NW'(1);
    end else if (frame_count_r > FRAMES) begin
      n_active = NW'(FRAMES);
    end else begin
      n_active = NW'(frame_count_r);
    end
    for (int i = 0; i < FRAMES; i++) begin
      act[i] = (i < n_active);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      item_v_r    <= start && !busy;
      out_valid_r <= item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r.page      <= in_page;
      item_r.start_seq <= in_start_sequence;
      item_r.last_ref  <= in_last_reference;
    end
    if (item_v_r) res_r <= res;
  end

  lpr_frames #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_frames (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_v (item_v_r),
    .item   (item_r),
    .act    (act),
    .res    (res)
  );

  assign out_valid         = out_valid_r;
  assign out_fault         = res_r.fault;
  assign out_frame_index   = res_r.frame_index;
  assign out_evicted_valid = res_r.evicted_valid;
  assign out_evicted_page  = res_r.evicted_page;
  assign out_fault_total   = res_r.fault_total;
  assign out_sequence_end  = res_r.seq_end;

endmodule

### rtl/core/lpr_victim.sv
module lpr_victim #(
  parameter int FRAMES = 16,
  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic [FRAMES-1:0]         act,
  input  logic [FRAMES-1:0][AW-1:0] age,
  output logic [IW-1:0]             vic_idx,
  output logic [AW-1:0]             vic_age
);

  localparam int LV = (FRAMES > 1) ? $clog2(FRAMES) : 0;
  localparam int P  = 1 << LV;

  logic          nv [LV+1][P];
  logic [AW-1:0] na [LV+1][P];
  logic [IW-1:0] ni [LV+1][P];

  // max-age tree over active frames, left side wins ties
  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int k = 0; k < P; k++) begin
        nv[l][k] = 1'b0;
        na[l][k] = '0;
        ni[l][k] = '0;
      end
    end
    for (int k = 0; k < FRAMES; k++) begin
      nv[0][k] = act[k];
      na[0][k] = age[k];
      ni[0][k] = IW'(k);
    end
    for (int l = 0; l < LV; l++) begin
      for (int k = 0; k < (P >> (l + 1)); k++) begin
        if (nv[l][2*k+1] && (!nv[l][2*k] || na[l][2*k+1] > na[l][2*k])) begin
          nv[l+1][k] = 1'b1;
          na[l+1][k] = na[l][2*k+1];
          ni[l+1][k] = ni[l][2*k+1];
        end else begin
          nv[l+1][k] = nv[l][2*k];
          na[l+1][k] = na[l][2*k];
          ni[l+1][k] = ni[l][2*k];
        end
      end
    end
    vic_idx = ni[LV][0];
    vic_age = na[LV][0];
  end

endmodule

### rtl/core/lpr_frames.sv
module lpr_frames import lpr_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_v,
  input  lpr_item_t         item,
  input  logic [FRAMES-1:0] act,
  output lpr_result_t       res
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int AW = IW;
  localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

  logic [FRAMES-1:0][PW-1:0] page_r;
  logic [FRAMES-1:0][AW-1:0] age_r, age_nxt;
  logic [FRAMES-1:0]         valid_r, valid_nxt;
  logic [FRAMES-1:0]         eff_valid, match, empty, hit_oh, fill_oh, vic_oh, slot_oh;
  logic [COUNT_W-1:0]        cnt_r, cnt_nxt, cnt_base;
  logic                      hit, found, evict, inc_all;
  logic [IW-1:0]             vic_idx, slot_idx;
  logic [AW-1:0]             vic_age, hit_age, old_rank;
  logic [PW-1:0]             pg, ev_page;

  lpr_victim #(.FRAMES(FRAMES)) u_victim (
    .act     (act),
    .age     (age_r),
    .vic_idx (vic_idx),
    .vic_age (vic_age)
  );

  always_comb begin
    pg        = item.page[PW-1:0];
    eff_valid = item.start_seq ? '0 : valid_r;
    for (int i = 0; i < FRAMES; i++) begin
      match[i]  = act[i] & eff_valid[i] & (page_r[i] == pg);
      vic_oh[i] = (vic_idx == IW'(i));
    end
    empty   = act & ~eff_valid;
    // lowest set bit
    hit_oh  = match & (~match + FRAMES'(1));
    fill_oh = empty & (~empty + FRAMES'(1));
    hit     = |match;
    found   = |empty;
    evict   = !hit && !found;
    inc_all = !hit && found;
    slot_oh = hit ? hit_oh : (found ? fill_oh : vic_oh);

    hit_age  = '0;
    ev_page  = '0;
    slot_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (hit_oh[i]) hit_age = hit_age | age_r[i];
      if (vic_oh[i]) ev_page = ev_page | page_r[i];
      if (slot_oh[i]) slot_idx = slot_idx | IW'(i);
    end
    old_rank = hit ? hit_age : vic_age;

    for (int i = 0; i < FRAMES; i++) begin
      age_nxt[i] = age_r[i];
      if (slot_oh[i]) begin
        age_nxt[i] = '0;
      end else if (eff_valid[i] && (inc_all || age_r[i] < old_rank)) begin
        age_nxt[i] = age_r[i] + 1'b1;
      end
    end
    valid_nxt = eff_valid | slot_oh;

    cnt_base = item.start_seq ? '0 : cnt_r;
    cnt_nxt  = (!hit && cnt_base != '1) ? cnt_base + 1'b1 : cnt_base;

    res.fault         = !hit;
    res.frame_index   = INDEX_W'(slot_idx);
    res.evicted_valid = evict;
    res.evicted_page  = evict ? PAGE_W'(ev_page) : '0;
    res.fault_total   = cnt_nxt;
    res.seq_end       = item.last_ref;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      age_r   <= '0;
      cnt_r   <= '0;
    end else if (item_v) begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_v && !hit) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (slot_oh[i]) page_r[i] <= pg;
      end
    end
  end

  a_slot_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    item_v |-> $onehot(slot_oh))
    else $error("slot select not one-hot");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    item_v && evict |-> (act & ~eff_valid) == '0)
    else $error("eviction while an active frame is empty");

  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    item_v && !item.start_seq |=> cnt_r >= $past(cnt_r))
    else $error("fault count went down without a new sequence");

  a_valid_keep: assert property (@(posedge clk) disable iff (!rst_n)
    item_v && !item.start_seq |=> (valid_r & $past(valid_r)) == $past(valid_r))
    else $error("frame lost its valid bit without a new sequence");

endmodule
